FILE: sv/i2c_mts_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: shared definitions
// Register indexes, status codes, transfer modes and the request, result,
// configuration and state records used across the block.
// ----------------------------------------------------------------------------
package i2c_mts_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRANSFER_MODE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TX_BYTE_ZERO   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TX_BYTE_ONE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TX_BYTE_TWO    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_ENABLE = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_LIMIT  = 3'd6;

  localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd1000;

  // Transfer modes
  localparam logic [1:0] MODE_READ_ONE   = 2'd0;
  localparam logic [1:0] MODE_WRITE_TWO  = 2'd1;
  localparam logic [1:0] MODE_READ_TWO   = 2'd2;
  localparam logic [1:0] MODE_WRITE_THREE = 2'd3;

  // Request operations
  localparam logic OP_STATUS = 1'b0;
  localparam logic OP_BEGIN  = 1'b1;

  // Controller status codes
  localparam logic [7:0] ST_START_SENT   = 8'h08;
  localparam logic [7:0] ST_RESTART_SENT = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
  localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

  localparam logic [7:0] READ_BIT = 8'h01;
  localparam logic [1:0] INDEX_MAX = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] status_code;
    logic [7:0] received_byte;
    logic       timeout_flag;
  } req_t;

  typedef struct packed {
    logic       load_data;
    logic [7:0] data_byte;
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_interrupt;
    logic       clear_timeout;
    logic       transfer_done;
    logic [7:0] first_rx_byte;
    logic [7:0] second_rx_byte;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [1:0]  transfer_mode;
    logic [7:0]  tx_byte_zero;
    logic [7:0]  tx_byte_one;
    logic [7:0]  tx_byte_two;
    logic        timeout_enable;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  byte_index;
    logic        done_flag;
    logic [15:0] unhandled_count;
    logic [7:0]  first_stored;
    logic [7:0]  second_stored;
  } state_t;

endpackage

FILE: sv/i2c_mts_if.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: channel interfaces
// Valid/ready channels for the request and result streams.
// ----------------------------------------------------------------------------
interface i2c_mts_req_if;
  logic                valid;
  logic                ready;
  i2c_mts_pkg::req_t   item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface i2c_mts_rsp_if;
  logic                valid;
  logic                ready;
  i2c_mts_pkg::rsp_t   item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: sv/i2c_mts_cfg_regs.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: configuration registers
// Holds the transaction set-up written through the plain write port.
// ----------------------------------------------------------------------------
module i2c_mts_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [i2c_mts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [i2c_mts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output i2c_mts_pkg::cfg_t                 cfg_o
);

  i2c_mts_pkg::cfg_t cfg_q, cfg_d;

  // Merge the write into the addressed field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        i2c_mts_pkg::CFG_DEVICE_ADDRESS: cfg_d.device_address = cfg_wdata_i[7:0];
        i2c_mts_pkg::CFG_TRANSFER_MODE:  cfg_d.transfer_mode  = cfg_wdata_i[1:0];
        i2c_mts_pkg::CFG_TX_BYTE_ZERO:   cfg_d.tx_byte_zero   = cfg_wdata_i[7:0];
        i2c_mts_pkg::CFG_TX_BYTE_ONE:    cfg_d.tx_byte_one    = cfg_wdata_i[7:0];
        i2c_mts_pkg::CFG_TX_BYTE_TWO:    cfg_d.tx_byte_two    = cfg_wdata_i[7:0];
        i2c_mts_pkg::CFG_TIMEOUT_ENABLE: cfg_d.timeout_enable = cfg_wdata_i[0];
        i2c_mts_pkg::CFG_TIMEOUT_LIMIT:  cfg_d.timeout_limit  = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{device_address: 8'h00,
                 transfer_mode:  i2c_mts_pkg::MODE_READ_ONE,
                 tx_byte_zero:   8'h00,
                 tx_byte_one:    8'h00,
                 tx_byte_two:    8'h00,
                 timeout_enable: 1'b0,
                 timeout_limit:  i2c_mts_pkg::TIMEOUT_LIMIT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/i2c_mts_decide.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: step decision
// Maps one request and the current sequencer state to the controller
// commands and the next state.
// ----------------------------------------------------------------------------
module i2c_mts_decide (
  input  i2c_mts_pkg::req_t    req_i,
  input  i2c_mts_pkg::cfg_t    cfg_i,
  input  i2c_mts_pkg::state_t  state_i,
  output i2c_mts_pkg::rsp_t    rsp_o,
  output i2c_mts_pkg::state_t  state_o
);

  logic       rd_mode;
  logic [1:0] end_count;
  logic [7:0] indexed_byte;
  logic [1:0] index_next;
  logic       load;
  logic [7:0] data;
  logic       handled;

  // Mode-dependent terms
  always_comb begin
    rd_mode = (cfg_i.transfer_mode inside {i2c_mts_pkg::MODE_READ_ONE,
                                           i2c_mts_pkg::MODE_READ_TWO});
    case (cfg_i.transfer_mode)
      i2c_mts_pkg::MODE_READ_ONE:    end_count = 2'd1;
      i2c_mts_pkg::MODE_WRITE_TWO:   end_count = 2'd2;
      i2c_mts_pkg::MODE_READ_TWO:    end_count = 2'd1;
      default:                       end_count = 2'd3;
    endcase
    case (state_i.byte_index)
      2'd0:    indexed_byte = cfg_i.tx_byte_zero;
      2'd1:    indexed_byte = cfg_i.tx_byte_one;
      2'd2:    indexed_byte = cfg_i.tx_byte_two;
      default: indexed_byte = 8'h00;
    endcase
    index_next = (state_i.byte_index == i2c_mts_pkg::INDEX_MAX) ?
                 i2c_mts_pkg::INDEX_MAX : state_i.byte_index + 2'd1;
  end

  // Decode the event
  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    load    = 1'b0;
    data    = 8'h00;
    handled = 1'b1;

    if (req_i.operation == i2c_mts_pkg::OP_BEGIN) begin
      state_o.byte_index      = 2'd0;
      state_o.done_flag       = 1'b0;
      state_o.unhandled_count = 16'd0;
    end else if (req_i.timeout_flag) begin
      rsp_o.clear_timeout = 1'b1;
    end else begin
      case (req_i.status_code)
        i2c_mts_pkg::ST_START_SENT: begin
          load = 1'b1;
          data = cfg_i.device_address;
          rsp_o.clear_interrupt = 1'b1;
        end
        i2c_mts_pkg::ST_ADDR_W_ACK: begin
          load = 1'b1;
          data = indexed_byte;
          state_o.byte_index = index_next;
          rsp_o.clear_interrupt = 1'b1;
        end
        i2c_mts_pkg::ST_ADDR_W_NACK: begin
          rsp_o.set_start       = 1'b1;
          rsp_o.set_stop        = 1'b1;
          rsp_o.clear_interrupt = 1'b1;
        end
        i2c_mts_pkg::ST_DATA_W_ACK: begin
          rsp_o.clear_interrupt = 1'b1;
          if (state_i.byte_index != end_count) begin
            load = 1'b1;
            data = indexed_byte;
            state_o.byte_index = index_next;
          end else if (rd_mode) begin
            rsp_o.set_start = 1'b1;
          end else begin
            rsp_o.set_stop    = 1'b1;
            state_o.done_flag = 1'b1;
          end
        end
        i2c_mts_pkg::ST_RESTART_SENT: begin
          if (rd_mode) begin
            load = 1'b1;
            data = cfg_i.device_address | i2c_mts_pkg::READ_BIT;
            rsp_o.clear_interrupt = 1'b1;
          end else begin
            handled = 1'b0;
          end
        end
        i2c_mts_pkg::ST_ADDR_R_ACK: begin
          if (rd_mode) begin
            rsp_o.clear_interrupt = 1'b1;
            rsp_o.set_ack = (cfg_i.transfer_mode == i2c_mts_pkg::MODE_READ_TWO);
          end else begin
            handled = 1'b0;
          end
        end
        i2c_mts_pkg::ST_DATA_R_ACK: begin
          if (cfg_i.transfer_mode == i2c_mts_pkg::MODE_READ_TWO) begin
            state_o.first_stored  = req_i.received_byte;
            rsp_o.clear_interrupt = 1'b1;
          end else begin
            handled = 1'b0;
          end
        end
        i2c_mts_pkg::ST_DATA_R_NACK: begin
          if (rd_mode) begin
            if (cfg_i.transfer_mode == i2c_mts_pkg::MODE_READ_ONE) begin
              state_o.first_stored = req_i.received_byte;
            end else begin
              state_o.second_stored = req_i.received_byte;
            end
            rsp_o.set_stop        = 1'b1;
            rsp_o.clear_interrupt = 1'b1;
            state_o.done_flag     = 1'b1;
          end else begin
            handled = 1'b0;
          end
        end
        default: handled = 1'b0;
      endcase

      // When timeouts are enabled, count unhandled events and force a stop past the limit
      if (!handled && cfg_i.timeout_enable) begin
        if (state_i.unhandled_count > cfg_i.timeout_limit) begin
          rsp_o.set_stop        = 1'b1;
          rsp_o.clear_interrupt = 1'b1;
          state_o.done_flag     = 1'b1;
        end
        state_o.unhandled_count = state_i.unhandled_count + 16'd1;
      end
    end

    rsp_o.load_data      = load;
    rsp_o.data_byte      = load ? data : 8'h00;
    rsp_o.transfer_done  = state_o.done_flag;
    rsp_o.first_rx_byte  = state_o.first_stored;
    rsp_o.second_rx_byte = state_o.second_stored;
  end

endmodule

FILE: sv/i2c_master_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer core
// Turns controller status events into the commands for the next bus step.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per handshake: a status event from the I2C
//   controller (status code, data register, timeout flag) or a begin that
//   readies a new transaction. rsp_o returns exactly one result per request:
//   the byte to load, the start/stop/ack/interrupt-clear/timeout-clear
//   commands, the done flag and the two stored received bytes.
//   The configuration port writes one register per cycle with cfg_we_i;
//   write it only while no request is in flight.
// Timing:
//   A request is registered on acceptance, decided once the result register
//   is free or draining and its result registered, which raises rsp_o.valid.
//   One request is accepted per cycle unless rsp_o.ready stalls the result;
//   the state update done in the decision cycle is what the following
//   request sees.
// Reset:
//   rst_ni clears the sequencer state and both stages; timeout_limit resets
//   to 1000, every other register to zero.
// Stall:
//   When rsp_o.ready is low the result holds, the request stage holds behind
//   it, and req_i.ready drops once both stages are full.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [i2c_mts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [i2c_mts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  i2c_mts_req_if.sink                       req_i,
  i2c_mts_rsp_if.source                     rsp_o
);

  i2c_mts_pkg::cfg_t   cfg;
  i2c_mts_pkg::state_t state_q, state_d;
  i2c_mts_pkg::req_t   req_q;
  i2c_mts_pkg::rsp_t   rsp_q, rsp_d;
  logic                req_valid_q;
  logic                rsp_valid_q;
  logic                req_fire;
  logic                step_fire;

  i2c_mts_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  i2c_mts_decide u_decide (
    .req_i  (req_q),
    .cfg_i  (cfg),
    .state_i(state_q),
    .rsp_o  (rsp_d),
    .state_o(state_d)
  );

  // Advance the request stage when the result register is free or draining
  assign step_fire   = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || step_fire;
  assign req_fire    = req_i.valid && req_i.ready;

  // Request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i.item;
    end
  end

  // Sequencer state, updated as each request is decided
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (step_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.item  = rsp_q;

`ifndef SYNTH
  // A decided begin leaves the transaction cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && req_q.operation == i2c_mts_pkg::OP_BEGIN |=>
      state_q.byte_index == 2'd0 && !state_q.done_flag && state_q.unhandled_count == 16'd0)
    else $error("begin did not clear the sequencer state");

  // A pending bus timeout only clears the flag and leaves the state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && req_q.operation == i2c_mts_pkg::OP_STATUS && req_q.timeout_flag |=>
      $stable(state_q) && rsp_q.clear_timeout && !rsp_q.clear_interrupt)
    else $error("timeout event changed the state or issued commands");

  // The byte index only moves forward between begins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && req_q.operation == i2c_mts_pkg::OP_STATUS |=>
      state_q.byte_index >= $past(state_q.byte_index))
    else $error("byte index went backwards");

  // The request side stays open while the result register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_q |-> req_i.ready)
    else $error("request stalled with an empty result register");

  // No byte is presented without a load command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_q.load_data |-> rsp_q.data_byte == 8'h00)
    else $error("data byte set without a load");
`endif

endmodule

FILE: tb/sv/tb_i2c_master_transfer_sequencer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the I2C master transfer sequencer core
// Drives status events and begin requests through the valid/ready request
// channel under several register settings, predicts every result with an
// in-bench copy of the sequencer state and compares each result field by
// field. Both sides idle in random bursts; one long receiver hold-off backs
// the pipeline up to the request side.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer_core;
  import i2c_mts_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned MaxPrinted = 30;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  i2c_mts_req_if req_if ();
  i2c_mts_rsp_if rsp_if ();

  i2c_master_transfer_sequencer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow registers and sequencer state of the predictor
  cfg_t   cfg_shadow;
  state_t seq_state;

  req_t pending_q[$];
  rsp_t cmd_expect_q[$];

  int unsigned n_errors   = 0;
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_settings = 0;
  int unsigned cycle_cnt  = 0;

  bit          idle_en  = 1'b1;
  bit          hold_go  = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_i2c_master_transfer_sequencer_core NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (n_errors < MaxPrinted) $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Fetch the byte at the current index and advance, saturating at three
  function automatic logic [7:0] take_tx_byte();
    logic [7:0] b;
    case (seq_state.byte_index)
      2'd0:    b = cfg_shadow.tx_byte_zero;
      2'd1:    b = cfg_shadow.tx_byte_one;
      2'd2:    b = cfg_shadow.tx_byte_two;
      default: b = 8'h00;
    endcase
    if (seq_state.byte_index != INDEX_MAX) seq_state.byte_index = seq_state.byte_index + 2'd1;
    return b;
  endfunction

  function automatic rsp_t decide_bus_step(req_t rq);
    rsp_t       r;
    logic       rd_mode;
    logic       handled;
    logic [1:0] end_cnt;
    r       = '0;
    handled = 1'b1;
    rd_mode = (cfg_shadow.transfer_mode == MODE_READ_ONE) ||
              (cfg_shadow.transfer_mode == MODE_READ_TWO);
    case (cfg_shadow.transfer_mode)
      MODE_WRITE_TWO:   end_cnt = 2'd2;
      MODE_WRITE_THREE: end_cnt = 2'd3;
      default:          end_cnt = 2'd1;
    endcase

    if (rq.operation == OP_BEGIN) begin
      seq_state.byte_index      = '0;
      seq_state.done_flag       = 1'b0;
      seq_state.unhandled_count = '0;
    end else if (rq.timeout_flag) begin
      r.clear_timeout = 1'b1;
    end else begin
      if (rq.status_code == ST_START_SENT) begin
        r.load_data = 1'b1;
        r.data_byte = cfg_shadow.device_address;
        r.clear_interrupt = 1'b1;
      end else if (rq.status_code == ST_ADDR_W_ACK) begin
        r.load_data = 1'b1;
        r.data_byte = take_tx_byte();
        r.clear_interrupt = 1'b1;
      end else if (rq.status_code == ST_ADDR_W_NACK) begin
        r.set_start = 1'b1;
        r.set_stop  = 1'b1;
        r.clear_interrupt = 1'b1;
      end else if (rq.status_code == ST_DATA_W_ACK) begin
        r.clear_interrupt = 1'b1;
        if (seq_state.byte_index != end_cnt) begin
          r.load_data = 1'b1;
          r.data_byte = take_tx_byte();
        end else if (rd_mode) begin
          r.set_start = 1'b1;
        end else begin
          r.set_stop = 1'b1;
          seq_state.done_flag = 1'b1;
        end
      end else if (rd_mode && rq.status_code == ST_RESTART_SENT) begin
        r.load_data = 1'b1;
        r.data_byte = cfg_shadow.device_address | READ_BIT;
        r.clear_interrupt = 1'b1;
      end else if (rd_mode && rq.status_code == ST_ADDR_R_ACK) begin
        r.clear_interrupt = 1'b1;
        r.set_ack = (cfg_shadow.transfer_mode == MODE_READ_TWO);
      end else if (cfg_shadow.transfer_mode == MODE_READ_TWO &&
                   rq.status_code == ST_DATA_R_ACK) begin
        seq_state.first_stored = rq.received_byte;
        r.clear_interrupt = 1'b1;
      end else if (rd_mode && rq.status_code == ST_DATA_R_NACK) begin
        if (cfg_shadow.transfer_mode == MODE_READ_ONE) seq_state.first_stored = rq.received_byte;
        else seq_state.second_stored = rq.received_byte;
        r.set_stop = 1'b1;
        r.clear_interrupt = 1'b1;
        seq_state.done_flag = 1'b1;
      end else begin
        handled = 1'b0;
      end

      // Force a stop once the unhandled count has run past the limit
      if (!handled && cfg_shadow.timeout_enable) begin
        if (seq_state.unhandled_count > cfg_shadow.timeout_limit) begin
          r.set_stop = 1'b1;
          r.clear_interrupt = 1'b1;
          seq_state.done_flag = 1'b1;
        end
        seq_state.unhandled_count = seq_state.unhandled_count + 16'd1;
      end
    end

    r.transfer_done  = seq_state.done_flag;
    r.first_rx_byte  = seq_state.first_stored;
    r.second_rx_byte = seq_state.second_stored;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Request driver
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      // Predict on acceptance
      if (req_if.valid && req_if.ready) begin
        cmd_expect_q.push_back(decide_bus_step(req_if.item));
        n_accepted++;
      end
      // Hold an unaccepted request, otherwise idle or present the next one
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_q.size() != 0 && idle_en && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          req_if.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          req_if.item  <= pending_q.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor
  // ------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    if (cmd_expect_q.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = cmd_expect_q.pop_front();
    check_field("load_data",       8'(got.load_data),       8'(want.load_data));
    check_field("data_byte",       got.data_byte,           want.data_byte);
    check_field("set_start",       8'(got.set_start),       8'(want.set_start));
    check_field("set_stop",        8'(got.set_stop),        8'(want.set_stop));
    check_field("set_ack",         8'(got.set_ack),         8'(want.set_ack));
    check_field("clear_interrupt", 8'(got.clear_interrupt), 8'(want.clear_interrupt));
    check_field("clear_timeout",   8'(got.clear_timeout),   8'(want.clear_timeout));
    check_field("transfer_done",   8'(got.transfer_done),   8'(want.transfer_done));
    check_field("first_rx_byte",   got.first_rx_byte,       want.first_rx_byte);
    check_field("second_rx_byte",  got.second_rx_byte,      want.second_rx_byte);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        check_result(rsp_if.item);
        n_results++;
      end
      // Stall in random bursts, and drop ready during the long hold-off
      if (recv_stall != 0) begin
        recv_stall--;
        rsp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 18) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (hold_cnt == 0);
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_used) begin
      hold_cnt  <= HoldCycles;
      hold_used <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic queue_request(logic op, logic [7:0] code, logic [7:0] rx, logic tflag);
    req_t rq;
    rq.operation     = op;
    rq.status_code   = code;
    rq.received_byte = rx;
    rq.timeout_flag  = tflag;
    pending_q.push_back(rq);
    n_queued++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  // Write every register; only called with the block idle
  task automatic apply_settings(cfg_t c);
    write_reg(CFG_DEVICE_ADDRESS, CfgDataW'(c.device_address));
    write_reg(CFG_TRANSFER_MODE,  CfgDataW'(c.transfer_mode));
    write_reg(CFG_TX_BYTE_ZERO,   CfgDataW'(c.tx_byte_zero));
    write_reg(CFG_TX_BYTE_ONE,    CfgDataW'(c.tx_byte_one));
    write_reg(CFG_TX_BYTE_TWO,    CfgDataW'(c.tx_byte_two));
    write_reg(CFG_TIMEOUT_ENABLE, CfgDataW'(c.timeout_enable));
    write_reg(CFG_TIMEOUT_LIMIT,  CfgDataW'(c.timeout_limit));
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow = c;
    n_settings++;
    @(negedge clk);
  endtask

  // Wait until every request has been answered, then let the pipeline settle
  task automatic drain();
    while (pending_q.size() != 0 || cmd_expect_q.size() != 0 || req_if.valid) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] known_code();
    case ($urandom_range(0, 7))
      0:       return ST_START_SENT;
      1:       return ST_RESTART_SENT;
      2:       return ST_ADDR_W_ACK;
      3:       return ST_ADDR_W_NACK;
      4:       return ST_DATA_W_ACK;
      5:       return ST_ADDR_R_ACK;
      6:       return ST_DATA_R_ACK;
      default: return ST_DATA_R_NACK;
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.device_address = 8'($urandom_range(0, 255));
    c.transfer_mode  = 2'($urandom_range(0, 3));
    c.tx_byte_zero   = 8'($urandom_range(0, 255));
    c.tx_byte_one    = 8'($urandom_range(0, 255));
    c.tx_byte_two    = 8'($urandom_range(0, 255));
    c.timeout_enable = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       c.timeout_limit = 16'd0;
      1:       c.timeout_limit = 16'($urandom_range(0, 6));
      2:       c.timeout_limit = 16'($urandom_range(0, 65535));
      default: c.timeout_limit = 16'hFFFF;
    endcase
    return c;
  endfunction

  // One transaction for the current mode, with skipped, corrupted and
  // timed-out steps mixed in
  task automatic queue_transaction();
    logic [7:0]  steps[$];
    logic [7:0]  code;
    logic        tflag;
    int unsigned r;
    if ($urandom_range(0, 9) != 0)
      queue_request(OP_BEGIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
    steps = {ST_START_SENT, ST_ADDR_W_ACK};
    case (cfg_shadow.transfer_mode)
      MODE_WRITE_TWO: begin
        steps.push_back(ST_DATA_W_ACK);
        steps.push_back(ST_DATA_W_ACK);
      end
      MODE_WRITE_THREE: begin
        steps.push_back(ST_DATA_W_ACK);
        steps.push_back(ST_DATA_W_ACK);
        steps.push_back(ST_DATA_W_ACK);
      end
      default: begin
        steps.push_back(ST_DATA_W_ACK);
        steps.push_back(ST_RESTART_SENT);
        steps.push_back(ST_ADDR_R_ACK);
        if (cfg_shadow.transfer_mode == MODE_READ_TWO) steps.push_back(ST_DATA_R_ACK);
        steps.push_back(ST_DATA_R_NACK);
      end
    endcase
    if ($urandom_range(0, 7) == 0) steps[$urandom_range(1, steps.size() - 1)] = ST_ADDR_W_NACK;
    if ($urandom_range(0, 3) == 0)
      steps.push_back($urandom_range(0, 1) ? ST_ADDR_W_ACK : ST_DATA_W_ACK);
    foreach (steps[i]) begin
      r     = $urandom_range(0, 19);
      code  = steps[i];
      tflag = 1'b0;
      if (r == 0) continue;
      else if (r == 1) code = 8'($urandom_range(0, 255));
      else if (r == 2) code = known_code();
      else if (r == 3) tflag = 1'b1;
      queue_request(OP_STATUS, code, 8'($urandom_range(0, 255)), tflag);
    end
  endtask

  task automatic run_random_phase(cfg_t c, int unsigned n_items);
    int unsigned start;
    apply_settings(c);
    start = n_queued;
    while (n_queued - start < n_items) queue_transaction();
    drain();
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    cfg_t        c;
    logic [7:0]  code;
    req_if.valid = 1'b0;
    req_if.item  = '0;
    rsp_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;

    cfg_shadow = '0;
    cfg_shadow.timeout_limit = TIMEOUT_LIMIT_RESET;
    seq_state  = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Two-byte write: full sequence, saturation of the index, read codes
    // treated as unhandled, forced stop over a zero limit, pending timeout
    c = '{device_address: 8'hA4, transfer_mode: MODE_WRITE_TWO, tx_byte_zero: 8'hFF,
          tx_byte_one: 8'h00, tx_byte_two: 8'h5A, timeout_enable: 1'b1,
          timeout_limit: 16'd0};
    apply_settings(c);
    queue_request(OP_BEGIN,  8'hFF,          8'hFF, 1'b1);
    queue_request(OP_STATUS, ST_START_SENT,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_W_ACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_W_ACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_W_ACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_W_ACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_W_ACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_R_NACK, 8'hFF, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_R_ACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_START_SENT,  8'h00, 1'b1);
    queue_request(OP_BEGIN,  8'h00,          8'h00, 1'b0);
    drain();

    // Two-byte read with the top device address and timeouts disabled
    c = '{device_address: 8'hFF, transfer_mode: MODE_READ_TWO, tx_byte_zero: 8'h3C,
          tx_byte_one: 8'hC3, tx_byte_two: 8'h00, timeout_enable: 1'b0,
          timeout_limit: 16'hFFFF};
    apply_settings(c);
    queue_request(OP_STATUS, ST_START_SENT,   8'h00, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_W_ACK,   8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_W_ACK,   8'h00, 1'b0);
    queue_request(OP_STATUS, ST_RESTART_SENT, 8'h00, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_R_ACK,   8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_R_ACK,   8'hFF, 1'b0);
    queue_request(OP_STATUS, ST_DATA_R_NACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_W_NACK,  8'h00, 1'b0);
    queue_request(OP_STATUS, 8'hFF,           8'hA5, 1'b0);
    drain();

    // One-byte read from address zero
    c = '{device_address: 8'h00, transfer_mode: MODE_READ_ONE, tx_byte_zero: 8'h81,
          tx_byte_one: 8'h00, tx_byte_two: 8'h00, timeout_enable: 1'b0,
          timeout_limit: 16'd0};
    apply_settings(c);
    queue_request(OP_BEGIN,  8'h00,           8'h00, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_W_ACK,   8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_W_ACK,   8'h00, 1'b0);
    queue_request(OP_STATUS, ST_RESTART_SENT, 8'h00, 1'b0);
    queue_request(OP_STATUS, ST_ADDR_R_ACK,   8'h00, 1'b0);
    queue_request(OP_STATUS, ST_DATA_R_NACK,  8'h81, 1'b0);
    drain();

    // Extreme settings
    c = '0;
    run_random_phase(c, 40);
    c = '{device_address: 8'hFF, transfer_mode: MODE_WRITE_THREE, tx_byte_zero: 8'hFF,
          tx_byte_one: 8'hFF, tx_byte_two: 8'hFF, timeout_enable: 1'b1,
          timeout_limit: 16'hFFFF};
    run_random_phase(c, 40);
    c = random_settings();
    c.transfer_mode  = MODE_WRITE_TWO;
    c.timeout_enable = 1'b1;
    c.timeout_limit  = 16'd0;
    run_random_phase(c, 40);

    // Random settings; the first one runs under the long hold-off
    hold_go = 1'b1;
    c = random_settings();
    c.transfer_mode = MODE_READ_TWO;
    run_random_phase(c, 40);
    repeat (5) run_random_phase(random_settings(), 40);

    // Run the unhandled count up to a small limit and well past it
    idle_en = 1'b0;
    c = random_settings();
    c.transfer_mode  = MODE_WRITE_THREE;
    c.timeout_enable = 1'b1;
    c.timeout_limit  = 16'd20;
    apply_settings(c);
    queue_request(OP_BEGIN, 8'h00, 8'h00, 1'b0);
    repeat (40) begin
      code = 8'($urandom_range(0, 255));
      if (code == ST_START_SENT || code == ST_ADDR_W_ACK || code == ST_ADDR_W_NACK ||
          code == ST_DATA_W_ACK)
        code = ST_DATA_R_NACK;
      queue_request(OP_STATUS, code, 8'($urandom_range(0, 255)), 1'b0);
    end
    drain();
    idle_en = 1'b1;

    run_random_phase(random_settings(), 40);

    // Final stretch at full rate on both sides
    idle_en = 1'b0;
    run_random_phase(random_settings(), 40);

    repeat (6) @(posedge clk);
    if (cmd_expect_q.size() != 0) report_mismatch("results still outstanding at the end");

    $display("Ran %0d requests under %0d register settings: all four modes, every status",
             n_accepted, n_settings);
    $display("code, begin, pending timeout, index saturation and forced stop past the limit");
    if (n_errors == 0) begin
      $display("tb_i2c_master_transfer_sequencer_core OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_i2c_master_transfer_sequencer_core NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/i2c_mts_pkg.sv
sv/i2c_mts_if.sv
sv/i2c_mts_cfg_regs.sv
sv/i2c_mts_decide.sv
sv/i2c_master_transfer_sequencer_core.sv
tb/sv/tb_i2c_master_transfer_sequencer_core.sv
